// File: design/mwf_pkg.sv
// Package for the median window filter: sizes, register codes and item types.
// No dependencies; every other file uses it by scoped names.
package mwf_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_WINDOW = 7;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
	localparam int OROW_W     = $clog2(MAX_HEIGHT);
	localparam int DIM_W      = 11;
	localparam int WIN_W      = 3;
	localparam int STORE_ROWS = 8;
	localparam int BANK_W     = $clog2(STORE_ROWS);
	localparam int WIN_N      = MAX_WINDOW * MAX_WINDOW;
	localparam int SEL_W      = $clog2(WIN_N / 2 + 1);
	localparam int RANK_W     = $clog2(WIN_N);
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);
	localparam int IDX_W      = 4;

	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT  = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_WINDOW_WIDTH  = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_WINDOW_HEIGHT = IDX_W'(3);

	localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = DIM_W'(256);
	localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = DIM_W'(256);
	localparam logic [WIN_W-1:0] RST_WINDOW       = WIN_W'(3);

	localparam logic [7:0] PAD_HIGH = 8'hFF;

	typedef logic [WIN_N-1:0][7:0] win_vec_t;

	typedef struct packed {
		win_vec_t           win;
		logic [SEL_W-1:0]   sel;
		logic               frame_end;
	} q_entry_t;

endpackage

// File: design/mwf_if.sv
// Channel interfaces of the median window filter: pixel in, result out, config write.
// Depends on mwf_pkg for widths.
interface mwf_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;
	logic       drain;
	modport source (output valid, output pixel, output drain, input ready);
	modport sink (input valid, input pixel, input drain, output ready);
endinterface

interface mwf_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] filtered;
	logic       frame_end;
	modport source (output valid, output filtered, output frame_end, input ready);
	modport sink (input valid, input filtered, input frame_end, output ready);
endinterface

interface mwf_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [mwf_pkg::IDX_W-1:0]    index;
	logic [mwf_pkg::DIM_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/mwf_front.sv
// Front end: config registers, raster counters, banked line store and window registers.
// Emits one masked window snapshot per output position. Depends on mwf_pkg, mwf_if.
module mwf_front (
	input  logic                        clk,
	input  logic                        arst_n,
	mwf_pix_if.sink                     pix,
	mwf_cfg_if.sink                     cfg,
	input  logic [mwf_pkg::QCNT_W-1:0]  q_level,
	output logic                        push,
	output mwf_pkg::q_entry_t           push_entry
);

	logic [mwf_pkg::DIM_W-1:0]  iw_q, ih_q;
	logic [mwf_pkg::WIN_W-1:0]  ww_q, wh_q;
	logic [mwf_pkg::COL_W-1:0]  col_q, ocol_q;
	logic [mwf_pkg::ROW_W-1:0]  row_q;
	logic [mwf_pkg::OROW_W-1:0] orow_q;

	logic [mwf_pkg::DIM_W-1:0]  w_eff, h_eff;
	logic [mwf_pkg::WIN_W-1:0]  ww_eff, wh_eff, down, right;
	logic                       in_frame, ignore, tick, emit, last_out, col_wrap, cfg_wr;
	logic [mwf_pkg::MAX_WINDOW-1:0] zero_d;
	logic [mwf_pkg::ROW_W-1:0]  rdn;
	logic [mwf_pkg::DIM_W+1:0]  reach;

	logic [7:0] ram [mwf_pkg::STORE_ROWS][mwf_pkg::MAX_WIDTH];
	logic [mwf_pkg::STORE_ROWS-1:0][7:0] rdata_q;

	logic                             s1_vld_q;
	logic                             emit_s1, fe_s1;
	logic [7:0]                       pix_s1;
	logic [mwf_pkg::MAX_WINDOW-1:0]   zero_s1;
	logic [mwf_pkg::BANK_W-1:0]       rowlo_s1;
	logic [mwf_pkg::COL_W-1:0]        ocol_s1;

	logic [mwf_pkg::MAX_WINDOW-1:0][mwf_pkg::MAX_WINDOW-1:0][7:0] win_q, win_nxt;
	logic [mwf_pkg::MAX_WINDOW-1:0][7:0] newcol;
	logic [mwf_pkg::MAX_WINDOW-1:0]      colok;
	logic [mwf_pkg::COL_W:0]             cr;
	logic [2*mwf_pkg::WIN_W-1:0]         nprod;

	always_comb begin
		if (iw_q == '0) begin
			w_eff = mwf_pkg::DIM_W'(1);
		end else if (iw_q > mwf_pkg::DIM_W'(mwf_pkg::MAX_WIDTH)) begin
			w_eff = mwf_pkg::DIM_W'(mwf_pkg::MAX_WIDTH);
		end else begin
			w_eff = iw_q;
		end
		if (ih_q == '0) begin
			h_eff = mwf_pkg::DIM_W'(1);
		end else if (ih_q > mwf_pkg::DIM_W'(mwf_pkg::MAX_HEIGHT)) begin
			h_eff = mwf_pkg::DIM_W'(mwf_pkg::MAX_HEIGHT);
		end else begin
			h_eff = ih_q;
		end
		if (ww_q == '0) begin
			ww_eff = mwf_pkg::WIN_W'(1);
		end else if (ww_q > mwf_pkg::WIN_W'(mwf_pkg::MAX_WINDOW)) begin
			ww_eff = mwf_pkg::WIN_W'(mwf_pkg::MAX_WINDOW);
		end else begin
			ww_eff = ww_q;
		end
		if (wh_q == '0) begin
			wh_eff = mwf_pkg::WIN_W'(1);
		end else if (wh_q > mwf_pkg::WIN_W'(mwf_pkg::MAX_WINDOW)) begin
			wh_eff = mwf_pkg::WIN_W'(mwf_pkg::MAX_WINDOW);
		end else begin
			wh_eff = wh_q;
		end
	end

	assign down  = wh_eff >> 1;
	assign right = ww_eff >> 1;
	assign nprod = (2*mwf_pkg::WIN_W)'(ww_eff) * (2*mwf_pkg::WIN_W)'(wh_eff);

	assign pix.ready = ((mwf_pkg::QCNT_W+1)'(q_level) + (mwf_pkg::QCNT_W+1)'(s1_vld_q))
		< (mwf_pkg::QCNT_W+1)'(mwf_pkg::QDEPTH);
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	assign in_frame = row_q < mwf_pkg::ROW_W'(h_eff);
	assign ignore   = pix.drain && in_frame;
	assign tick     = pix.valid && pix.ready && !ignore;

	// raster index reached the window reach; right may exceed a narrow row
	assign rdn   = row_q - mwf_pkg::ROW_W'(down);
	assign reach = (mwf_pkg::DIM_W+2)'(col_q)
		+ (rdn[0] ? (mwf_pkg::DIM_W+2)'(w_eff) : '0)
		+ (rdn[1] ? ((mwf_pkg::DIM_W+2)'(w_eff) << 1) : '0);
	assign emit  = (row_q >= mwf_pkg::ROW_W'(down))
		&& ((rdn > mwf_pkg::ROW_W'(2)) || (reach >= (mwf_pkg::DIM_W+2)'(right)));

	assign col_wrap = col_q == mwf_pkg::COL_W'(w_eff - mwf_pkg::DIM_W'(1));
	assign last_out = emit && orow_q == mwf_pkg::OROW_W'(h_eff - mwf_pkg::DIM_W'(1))
		&& ocol_q == mwf_pkg::COL_W'(w_eff - mwf_pkg::DIM_W'(1));

	always_comb begin
		for (int d = 0; d < mwf_pkg::MAX_WINDOW; d++) begin
			zero_d[d] = (mwf_pkg::ROW_W'(d) > row_q)
				|| ((row_q - mwf_pkg::ROW_W'(d)) >= mwf_pkg::ROW_W'(h_eff));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iw_q   <= mwf_pkg::RST_IMAGE_WIDTH;
			ih_q   <= mwf_pkg::RST_IMAGE_HEIGHT;
			ww_q   <= mwf_pkg::RST_WINDOW;
			wh_q   <= mwf_pkg::RST_WINDOW;
			col_q  <= '0;
			row_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg.index)
				mwf_pkg::REG_IMAGE_WIDTH: begin
					iw_q <= cfg.data;
				end
				mwf_pkg::REG_IMAGE_HEIGHT: begin
					ih_q <= cfg.data;
				end
				mwf_pkg::REG_WINDOW_WIDTH: begin
					ww_q <= cfg.data[mwf_pkg::WIN_W-1:0];
				end
				mwf_pkg::REG_WINDOW_HEIGHT: begin
					wh_q <= cfg.data[mwf_pkg::WIN_W-1:0];
				end
				default: begin
				end
			endcase
			if (cfg.index <= mwf_pkg::REG_WINDOW_HEIGHT) begin
				col_q  <= '0;
				row_q  <= '0;
				ocol_q <= '0;
				orow_q <= '0;
			end
		end else if (tick) begin
			if (last_out) begin
				col_q  <= '0;
				row_q  <= '0;
				ocol_q <= '0;
				orow_q <= '0;
			end else begin
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_q + mwf_pkg::ROW_W'(1);
				end else begin
					col_q <= col_q + mwf_pkg::COL_W'(1);
				end
				if (emit) begin
					if (ocol_q == mwf_pkg::COL_W'(w_eff - mwf_pkg::DIM_W'(1))) begin
						ocol_q <= '0;
						orow_q <= orow_q + mwf_pkg::OROW_W'(1);
					end else begin
						ocol_q <= ocol_q + mwf_pkg::COL_W'(1);
					end
				end
			end
		end
	end

	for (genvar b = 0; b < mwf_pkg::STORE_ROWS; b++) begin : g_bank
		always_ff @(posedge clk) begin
			if (tick && in_frame && row_q[mwf_pkg::BANK_W-1:0] == mwf_pkg::BANK_W'(b)) begin
				ram[b][col_q] <= pix.pixel;
			end
			if (tick) begin
				rdata_q[b] <= ram[b][col_q];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else begin
			s1_vld_q <= tick;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			pix_s1   <= pix.pixel;
			zero_s1  <= zero_d;
			rowlo_s1 <= row_q[mwf_pkg::BANK_W-1:0];
			emit_s1  <= emit;
			fe_s1    <= last_out;
			ocol_s1  <= ocol_q;
		end
		if (s1_vld_q) begin
			win_q <= win_nxt;
		end
	end

	always_comb begin
		for (int d = 0; d < mwf_pkg::MAX_WINDOW; d++) begin
			if (zero_s1[d]) begin
				newcol[d] = '0;
			end else if (d == 0) begin
				newcol[d] = pix_s1;
			end else begin
				newcol[d] = rdata_q[rowlo_s1 - mwf_pkg::BANK_W'(d)];
			end
			win_nxt[d][0] = newcol[d];
			for (int j = 1; j < mwf_pkg::MAX_WINDOW; j++) begin
				win_nxt[d][j] = win_q[d][j-1];
			end
		end
	end

	assign cr = (mwf_pkg::COL_W+1)'(ocol_s1) + (mwf_pkg::COL_W+1)'(right);

	always_comb begin
		for (int j = 0; j < mwf_pkg::MAX_WINDOW; j++) begin
			colok[j] = ((mwf_pkg::COL_W+1)'(j) <= cr)
				&& (mwf_pkg::DIM_W'(cr - (mwf_pkg::COL_W+1)'(j)) < w_eff);
		end
		for (int d = 0; d < mwf_pkg::MAX_WINDOW; d++) begin
			for (int j = 0; j < mwf_pkg::MAX_WINDOW; j++) begin
				if (mwf_pkg::WIN_W'(d) >= wh_eff || mwf_pkg::WIN_W'(j) >= ww_eff) begin
					push_entry.win[d*mwf_pkg::MAX_WINDOW + j] = mwf_pkg::PAD_HIGH;
				end else if (colok[j]) begin
					push_entry.win[d*mwf_pkg::MAX_WINDOW + j] = win_nxt[d][j];
				end else begin
					push_entry.win[d*mwf_pkg::MAX_WINDOW + j] = '0;
				end
			end
		end
	end

	assign push_entry.sel       = mwf_pkg::SEL_W'(nprod >> 1);
	assign push_entry.frame_end = fe_s1;
	assign push                 = s1_vld_q && emit_s1;

endmodule

// File: design/mwf_queue.sv
// Short queue of window snapshots between the front end and the median back end.
// Depends on mwf_pkg.
module mwf_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  mwf_pkg::q_entry_t           push_entry,
	input  logic                        pop,
	output logic                        nonempty,
	output logic [mwf_pkg::QCNT_W-1:0]  level,
	output mwf_pkg::q_entry_t           head
);

	mwf_pkg::q_entry_t            mem_q [mwf_pkg::QDEPTH];
	logic [mwf_pkg::QPTR_W-1:0]   wr_q, rd_q;
	logic [mwf_pkg::QCNT_W-1:0]   cnt_q;
	logic                         do_pop;

	assign nonempty = cnt_q != '0;
	assign level    = cnt_q;
	assign head     = mem_q[rd_q];
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + mwf_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + mwf_pkg::QPTR_W'(1);
			end
			unique case ({push, do_pop})
				2'b10: cnt_q <= cnt_q + mwf_pkg::QCNT_W'(1);
				2'b01: cnt_q <= cnt_q - mwf_pkg::QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

endmodule

// File: design/mwf_back.sv
// Back end: rank-based selection of the median from a window snapshot, three stages.
// Stage one compares, stage two counts ranks, stage three is the output register.
// Depends on mwf_pkg, mwf_if.
module mwf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               nonempty,
	input  mwf_pkg::q_entry_t  head,
	output logic               pop,
	mwf_res_if.source          res
);

	logic en;

	logic                                           vld_s1, vld_s2, vld_q;
	mwf_pkg::win_vec_t                              v_s1, v_s2;
	logic [mwf_pkg::WIN_N-1:0][mwf_pkg::WIN_N-1:0]  bef_s1;
	logic [mwf_pkg::WIN_N-1:0][mwf_pkg::WIN_N-1:0]  bef;
	logic [mwf_pkg::SEL_W-1:0]                      sel_s1, sel_s2;
	logic                                           fe_s1, fe_s2, fe_q;
	logic [mwf_pkg::WIN_N-1:0][mwf_pkg::RANK_W-1:0] rank_s2;
	logic [7:0]                                     filt_q, pick;

	assign en  = !vld_q || res.ready;
	assign pop = en && nonempty;

	always_comb begin
		for (int i = 0; i < mwf_pkg::WIN_N; i++) begin
			for (int j = 0; j < mwf_pkg::WIN_N; j++) begin
				if (j < i) begin
					bef[i][j] = head.win[j] <= head.win[i];
				end else begin
					bef[i][j] = head.win[j] < head.win[i];
				end
			end
		end
	end

	always_comb begin
		pick = '0;
		for (int i = 0; i < mwf_pkg::WIN_N; i++) begin
			if (rank_s2[i] == mwf_pkg::RANK_W'(sel_s2)) begin
				pick = pick | v_s2[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s1 <= nonempty;
			vld_s2 <= vld_s1;
			vld_q  <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1   <= head.win;
			bef_s1 <= bef;
			sel_s1 <= head.sel;
			fe_s1  <= head.frame_end;
			v_s2   <= v_s1;
			sel_s2 <= sel_s1;
			fe_s2  <= fe_s1;
			for (int i = 0; i < mwf_pkg::WIN_N; i++) begin
				rank_s2[i] <= mwf_pkg::RANK_W'($countones(bef_s1[i]));
			end
			filt_q <= pick;
			fe_q   <= fe_s2;
		end
	end

	assign res.valid     = vld_q;
	assign res.filtered  = filt_q;
	assign res.frame_end = fe_q;

endmodule

// File: design/median_window_filter.sv
// Median window filter top: front end, snapshot queue, median back end.
// One item per cycle while the queue has room; a position's result leaves after
// the item completing its window (down*width + right items after its own pixel).
// Reset: counters clear, registers 256, 256, 3, 3; line store is not cleared.
// Depends on mwf_pkg, mwf_if, mwf_front, mwf_queue, mwf_back.
module median_window_filter (
	input  logic      clk,
	input  logic      arst_n,
	mwf_pix_if.sink   pix,
	mwf_cfg_if.sink   cfg,
	mwf_res_if.source res
);

	logic                        push, pop, nonempty;
	logic [mwf_pkg::QCNT_W-1:0]  level;
	mwf_pkg::q_entry_t           push_entry, head;

	mwf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix        (pix),
		.cfg        (cfg),
		.q_level    (level),
		.push       (push),
		.push_entry (push_entry)
	);

	mwf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.nonempty   (nonempty),
		.level      (level),
		.head       (head)
	);

	mwf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.nonempty (nonempty),
		.head     (head),
		.pop      (pop),
		.res      (res)
	);

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= mwf_pkg::QCNT_W'(mwf_pkg::QDEPTH))
		else $error("queue level above depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(level == mwf_pkg::QCNT_W'(mwf_pkg::QDEPTH)) |-> !push)
		else $error("push into full queue");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(push && level == mwf_pkg::QCNT_W'(0)) |=> nonempty)
		else $error("pushed snapshot lost");

endmodule
